>>> hdl/scov_pkg.sv
package scov_pkg;

    localparam int NMICS    = 6;
    localparam int CHANNELS = 6;
    localparam int WINDOW   = 1024;

    localparam int SMP_W  = 16;
    localparam int PROD_W = 2 * SMP_W;
    localparam int SUM_W  = 42;
    localparam int IDX_W  = 3;

    localparam int ENTRIES = CHANNELS * CHANNELS;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int SEEN_W  = $clog2(WINDOW + 1);

    typedef logic signed [SMP_W-1:0]  t_sample;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [IDX_W-1:0]         t_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load_in;
        logic  mac_step;
        logic  first;
        logic  rd_en;
        t_addr rd_addr;
        t_idx  row;
        t_idx  col;
        logic  emit_load;
        logic  last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_taken;
    } t_sts;

endpackage

>>> hdl/scov_in_if.sv
interface scov_in_if;
    import scov_pkg::*;

    logic    valid;
    logic    ready;
    logic    capture_start;
    t_sample mic0_sample;
    t_sample mic1_sample;
    t_sample mic2_sample;
    t_sample mic3_sample;
    t_sample mic4_sample;
    t_sample mic5_sample;

    modport source (
        output valid, capture_start, mic0_sample, mic1_sample, mic2_sample,
               mic3_sample, mic4_sample, mic5_sample,
        input  ready
    );

    modport sink (
        input  valid, capture_start, mic0_sample, mic1_sample, mic2_sample,
               mic3_sample, mic4_sample, mic5_sample,
        output ready
    );
endinterface

>>> hdl/scov_out_if.sv
interface scov_out_if;
    import scov_pkg::*;

    logic valid;
    logic ready;
    t_idx row_index;
    t_idx col_index;
    t_sum cov_value;
    logic last_entry;

    modport source (
        output valid, row_index, col_index, cov_value, last_entry,
        input  ready
    );

    modport sink (
        input  valid, row_index, col_index, cov_value, last_entry,
        output ready
    );
endinterface

>>> hdl/spatial_covariance_accumulator.sv
// Six-channel sample covariance accumulator. A vector with capture_start set
// opens a capture and the first 1024 vectors of it are summed pairwise into a
// 6x6 matrix; the 1024th vector triggers 36 result items in row-major order,
// each the sum of products read as the mean with 10 fraction bits, and the
// final one flagged by last_entry. Vectors outside a capture are dropped. An
// accepted vector inside a capture occupies the block while one 16x16
// multiplier and one RAM of 36 sums are stepped through the matrix, one
// entry per cycle. A dropped vector leaves the block idle and ready. For
// each result item the sum is read, registered and held until taken.
module spatial_covariance_accumulator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scov_in_if.sink    i_in,
    scov_out_if.source o_out
);
    import scov_pkg::*;

    t_cmd    cmd;
    t_sts    sts;
    t_sample smp [NMICS];

    assign smp[0] = i_in.mic0_sample;
    assign smp[1] = i_in.mic1_sample;
    assign smp[2] = i_in.mic2_sample;
    assign smp[3] = i_in.mic3_sample;
    assign smp[4] = i_in.mic4_sample;
    assign smp[5] = i_in.mic5_sample;

    scov_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_start    (i_in.capture_start),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    scov_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_smp       (smp),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .o_row       (o_out.row_index),
        .o_col       (o_out.col_index),
        .o_value     (o_out.cov_value),
        .o_last      (o_out.last_entry)
    );

    // No new vector is taken while a result item is pending.
    a_no_input_during_emit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready
    ) else $error("input ready while a result item is pending");

    // The final entry sits at the bottom-right corner of the matrix.
    a_last_is_corner: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_entry) |->
            (o_out.row_index == t_idx'(CHANNELS - 1)) &&
            (o_out.col_index == t_idx'(CHANNELS - 1))
    ) else $error("last entry flagged away from the final matrix position");

    // Handing off the final entry returns the block to taking vectors.
    a_ready_after_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_entry) |=> i_in.ready
    ) else $error("block not ready after the final entry");
endmodule

>>> hdl/scov_ram.sv
module scov_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> hdl/scov_ctrl.sv
module scov_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_start,
    input  scov_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output scov_pkg::t_cmd o_cmd
);
    import scov_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MAC       = 3'd1;
    localparam logic [2:0] ST_EMIT_RD   = 3'd2;
    localparam logic [2:0] ST_EMIT_LD   = 3'd3;
    localparam logic [2:0] ST_EMIT_WAIT = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [SEEN_W-1:0] r_seen, n_seen;
    logic              r_first, n_first;
    logic              r_emit, n_emit;
    t_addr             r_step, n_step;
    t_idx              r_row, n_row;
    t_idx              r_col, n_col;

    logic              accept;
    logic              at_end;
    logic [SEEN_W-1:0] seen_eff;
    logic [SEEN_W-1:0] seen_inc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign at_end     = (r_step == t_addr'(ENTRIES - 1));
    assign seen_eff   = i_start ? '0 : r_seen;
    assign seen_inc   = seen_eff + SEEN_W'(1);

    always_comb begin
        n_state = r_state;
        n_seen  = r_seen;
        n_first = r_first;
        n_emit  = r_emit;
        n_step  = r_step;
        n_row   = r_row;
        n_col   = r_col;

        o_cmd           = '0;
        o_cmd.load_in   = accept;
        o_cmd.first     = r_first;
        o_cmd.rd_addr   = r_step;
        o_cmd.row       = r_row;
        o_cmd.col       = r_col;
        o_cmd.last      = at_end;

        case (r_state)
            ST_IDLE: begin
                // Items outside an open capture are dropped here.
                if (accept && (seen_eff < SEEN_W'(WINDOW))) begin
                    n_seen  = seen_inc;
                    n_first = i_start;
                    n_emit  = (seen_inc == SEEN_W'(WINDOW));
                    n_step  = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                o_cmd.mac_step = 1'b1;
                o_cmd.rd_en    = 1'b1;
                if (at_end) begin
                    n_step  = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = r_emit ? ST_EMIT_RD : ST_IDLE;
                end else begin
                    n_step = r_step + t_addr'(1);
                    if (r_col == t_idx'(CHANNELS - 1)) begin
                        n_col = '0;
                        n_row = r_row + t_idx'(1);
                    end else begin
                        n_col = r_col + t_idx'(1);
                    end
                end
            end
            ST_EMIT_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                o_cmd.emit_load = 1'b1;
                n_state         = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (i_sts.out_taken) begin
                    if (at_end) begin
                        n_emit  = 1'b0;
                        n_step  = '0;
                        n_row   = '0;
                        n_col   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_step = r_step + t_addr'(1);
                        if (r_col == t_idx'(CHANNELS - 1)) begin
                            n_col = '0;
                            n_row = r_row + t_idx'(1);
                        end else begin
                            n_col = r_col + t_idx'(1);
                        end
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seen  <= SEEN_W'(WINDOW);
            r_first <= 1'b0;
            r_emit  <= 1'b0;
            r_step  <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_first <= n_first;
            r_emit  <= n_emit;
            r_step  <= n_step;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end
endmodule

>>> hdl/scov_dp.sv
module scov_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  scov_pkg::t_cmd   i_cmd,
    input  scov_pkg::t_sample i_smp [scov_pkg::NMICS],
    input  logic             i_out_ready,
    output scov_pkg::t_sts   o_sts,
    output logic             o_out_valid,
    output scov_pkg::t_idx   o_row,
    output scov_pkg::t_idx   o_col,
    output scov_pkg::t_sum   o_value,
    output logic             o_last
);
    import scov_pkg::*;

    t_sample r_smp [NMICS];
    t_prod   r_prod;
    logic    r_wr_pend;
    logic    r_wr_first;
    t_addr   r_wr_addr;

    logic    r_out_valid;
    t_idx    r_out_row;
    t_idx    r_out_col;
    t_sum    r_out_value;
    logic    r_out_last;

    t_sum    rd_data;
    t_sum    wr_data;
    t_sum    prod_ext;
    logic    out_taken;

    assign prod_ext = {{(SUM_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    // The first vector of a capture overwrites whatever the entry held before.
    assign wr_data  = (r_wr_first ? t_sum'(0) : rd_data) + prod_ext;

    scov_ram #(
        .WIDTH (SUM_W),
        .DEPTH (ENTRIES)
    ) u_sums (
        .i_clk     (i_clk),
        .i_wr_en   (r_wr_pend),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_cmd.rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_smp <= i_smp;
        end
        r_prod     <= t_prod'(r_smp[i_cmd.row]) * t_prod'(r_smp[i_cmd.col]);
        r_wr_first <= i_cmd.first;
        r_wr_addr  <= i_cmd.rd_addr;
        if (i_cmd.emit_load) begin
            r_out_row   <= i_cmd.row;
            r_out_col   <= i_cmd.col;
            r_out_value <= rd_data;
            r_out_last  <= i_cmd.last;
        end
    end

    assign out_taken = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.mac_step;
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_taken = out_taken;
    assign o_out_valid     = r_out_valid;
    assign o_row           = r_out_row;
    assign o_col           = r_out_col;
    assign o_value         = r_out_value;
    assign o_last          = r_out_last;
endmodule

>>> tb/spatial_covariance_accumulator_tb.sv
module spatial_covariance_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scov_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 600;
    localparam int DRAIN_WAIT  = 150;

    typedef struct packed {
        logic                start;
        t_sample [NMICS-1:0] mic;
    } t_vec;

    typedef struct packed {
        t_idx row;
        t_idx col;
        t_sum value;
        logic last;
    } t_entry;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    scov_in_if  in_if ();
    scov_out_if out_if ();

    spatial_covariance_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #4 i_clk = ~i_clk;

    t_vec   vec_pending[$];
    t_entry cov_expected[$];
    t_sum   pair_sum[NMICS*NMICS];
    int     window_fill = WINDOW;
    int     send_idle   = 17;
    int     recv_idle   = 62;
    int     errors      = 0;
    int     quiet       = 0;
    int     hold_left   = 0;
    bit     hold_armed  = 1'b0;
    bit     hold_done   = 1'b0;
    logic   in_took     = 1'b0;

    // Folds an accepted vector of an open capture into the running sums and,
    // when the window closes, queues the whole matrix in row-major order.
    task automatic fold_vector(input t_vec v);
        t_sum   a;
        t_sum   b;
        t_entry e;
        if (v.start) begin
            foreach (pair_sum[k]) pair_sum[k] = '0;
            window_fill = 0;
        end
        if (window_fill < WINDOW) begin
            for (int r = 0; r < CHANNELS; r++) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    a = t_sum'(t_sample'(v.mic[r]));
                    b = t_sum'(t_sample'(v.mic[c]));
                    pair_sum[r*NMICS+c] = pair_sum[r*NMICS+c] + a * b;
                end
            end
            window_fill++;
            if (window_fill == WINDOW) begin
                for (int r = 0; r < CHANNELS; r++) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        e.row   = t_idx'(r);
                        e.col   = t_idx'(c);
                        e.value = pair_sum[r*NMICS+c];
                        e.last  = (r == CHANNELS - 1) && (c == CHANNELS - 1);
                        cov_expected.push_back(e);
                    end
                end
            end
        end
    endtask

    // Samples lean toward the rails so that extreme products reach the sums.
    function automatic t_sample pick_sample();
        int sel;
        sel = $urandom_range(15);
        case (sel)
            0, 1:    pick_sample = t_sample'(16'h8000);
            2, 3:    pick_sample = t_sample'(16'h7FFF);
            4:       pick_sample = '0;
            5:       pick_sample = t_sample'(16'hFFFF);
            default: pick_sample = t_sample'($urandom);
        endcase
    endfunction

    // Queues count vectors; the first one opens a capture when opens is set.
    // Pinned vectors put the negative rail on the lower half of the array
    // and the positive rail on the upper half.
    task automatic add_vectors(input int count, input bit opens, input bit pinned);
        t_vec v;
        for (int n = 0; n < count; n++) begin
            v.start = opens && (n == 0);
            for (int m = 0; m < NMICS; m++) begin
                if (pinned)
                    v.mic[m] = (m < NMICS / 2) ? t_sample'(16'h8000) : t_sample'(16'h7FFF);
                else
                    v.mic[m] = pick_sample();
            end
            vec_pending.push_back(v);
        end
    endtask

    task automatic add_uniform(input bit opens, input t_sample value);
        t_vec v;
        v.start = opens;
        for (int m = 0; m < NMICS; m++) v.mic[m] = value;
        vec_pending.push_back(v);
    endtask

    task automatic wait_drained();
        while (vec_pending.size() != 0) @(posedge i_clk);
    endtask

    // Sender: a new item goes out only once the previous one was taken.
    always @(negedge i_clk) begin
        t_vec v;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_took || !in_if.valid) begin
            if (vec_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
                v = vec_pending.pop_front();
                in_if.valid         <= 1'b1;
                in_if.capture_start <= v.start;
                in_if.mic0_sample   <= v.mic[0];
                in_if.mic1_sample   <= v.mic[1];
                in_if.mic2_sample   <= v.mic[2];
                in_if.mic3_sample   <= v.mic[3];
                in_if.mic4_sample   <= v.mic[4];
                in_if.mic5_sample   <= v.mic[5];
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on the first result
    // seen after it is armed.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_armed && !hold_done && out_if.valid) begin
            out_if.ready <= 1'b0;
            hold_done    <= 1'b1;
            hold_left    <= LONG_HOLD;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_vec   v;
        t_entry got;
        t_entry want;
        logic   took_in;
        logic   took_out;
        took_in  = in_if.valid && in_if.ready;
        took_out = out_if.valid && out_if.ready;
        if (i_rst_n) begin
            in_took <= took_in;
            quiet   <= (took_in || took_out) ? 0 : quiet + 1;
            if (took_in) begin
                v.start  = in_if.capture_start;
                v.mic[0] = in_if.mic0_sample;
                v.mic[1] = in_if.mic1_sample;
                v.mic[2] = in_if.mic2_sample;
                v.mic[3] = in_if.mic3_sample;
                v.mic[4] = in_if.mic4_sample;
                v.mic[5] = in_if.mic5_sample;
                fold_vector(v);
            end
            if (took_out) begin
                got.row   = out_if.row_index;
                got.col   = out_if.col_index;
                got.value = out_if.cov_value;
                got.last  = out_if.last_entry;
                if (cov_expected.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected entry row %0d col %0d value %0d last %0b",
                             $time, got.row, got.col, got.value, got.last);
                end else begin
                    want = cov_expected.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch, expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 $time, want.row, want.col, want.value, want.last,
                                 got.row, got.col, got.value, got.last);
                    end
                end
            end
        end
    end

    initial begin
        while (quiet < QUIET_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        in_if.valid         = 1'b0;
        in_if.capture_start = 1'b0;
        in_if.mic0_sample   = '0;
        in_if.mic1_sample   = '0;
        in_if.mic2_sample   = '0;
        in_if.mic3_sample   = '0;
        in_if.mic4_sample   = '0;
        in_if.mic5_sample   = '0;
        out_if.ready        = 1'b0;
        foreach (pair_sum[k]) pair_sum[k] = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Vectors before any capture are dropped, then a short capture at the
        // rails, then a restart that throws the partial sums away.
        add_vectors(3, 1'b0, 1'b0);
        add_uniform(1'b1, t_sample'(16'h8000));
        add_uniform(1'b0, t_sample'(16'h7FFF));
        add_uniform(1'b0, '0);
        add_uniform(1'b0, t_sample'(16'hFFFF));
        add_vectors(1, 1'b0, 1'b1);
        add_vectors(6, 1'b0, 1'b0);
        add_vectors(5, 1'b1, 1'b0);

        add_vectors($urandom_range(1, 30), 1'b1, 1'b0);
        add_vectors($urandom_range(1, 10), 1'b0, 1'b0);
        wait_drained();

        // One full window; the next capture opens right after it closes and
        // waits behind the long hold-off on the results.
        send_idle  = 62;
        recv_idle  = 17;
        hold_armed = 1'b1;
        add_vectors(WINDOW, 1'b1, 1'b0);
        add_vectors(3, 1'b1, 1'b0);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        add_vectors(5, 1'b1, 1'b1);
        add_vectors(4, 1'b0, 1'b0);

        while (vec_pending.size() != 0 || in_if.valid) @(posedge i_clk);
        while (cov_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
hdl/scov_pkg.sv
hdl/scov_in_if.sv
hdl/scov_out_if.sv
hdl/scov_ram.sv
hdl/scov_ctrl.sv
hdl/scov_dp.sv
hdl/spatial_covariance_accumulator.sv
tb/spatial_covariance_accumulator_tb.sv
